>>> sv/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants for the Euler angle to quaternion converter
// Widths, CORDIC arctangent table and pipeline depths used by all modules.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CORDIC_STEPS         = 16;
  localparam int RESULT_FRACTION_BITS = 15;

  // The arctangent table has 24 entries, so the step count is capped there.
  localparam int NSTEP = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam int ANGLE_W = 17;
  localparam int QUAT_W  = 16;
  localparam int SC_W    = 32;  // sine and cosine, Q2.30
  localparam int CW      = 34;  // CORDIC datapath width
  localparam int RW      = 34;  // rounded pair product, Q30

  localparam int LANE_STAGES  = NSTEP + 5;
  localparam int MERGE_STAGES = 5;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  localparam int RES_SHIFT = 60 - RESULT_FRACTION_BITS;

  localparam logic signed [17:0] QUARTER_TURN = 18'sd23040;
  localparam logic signed [17:0] HALF_TURN    = 18'sd46080;
  localparam logic [16:0] RAD_INT  = 17'd73204;   // floor(pi_q30_scale / 46080)
  localparam logic [14:0] RAD_FRAC = 15'd19106;   // remainder of that division
  localparam logic [14:0] RAD_HALF = 15'd23040;   // rounding term
  localparam logic [19:0] RECIP_45 = 20'd745655;  // ceil(2^25 / 45)
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic signed [31:0] ATAN_Q30 [24] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

endpackage

>>> sv/e2q_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_lane: half-angle sine and cosine for one input angle
// Quadrant folding, degree to radian scaling and a pipelined CORDIC.
// ----------------------------------------------------------------------------
module e2q_lane
  import e2q_pkg::*;
(
  input  logic                          clk_i,
  input  logic [LANE_STAGES-1:0]        en_i,
  input  logic signed [ANGLE_W-1:0]     angle_i,
  output logic signed [SC_W-1:0]        sin_o,
  output logic signed [SC_W-1:0]        cos_o
);

  // Stage 0: fold into plus or minus a quarter turn and take the magnitude.
  logic signed [17:0] d_ext, d_red;
  logic               flip_d;
  logic [14:0]        mag_d;
  logic [14:0]        mag_q;
  logic               neg_q0, flip_q0;

  always_comb begin
    d_ext  = 18'(angle_i);
    d_red  = d_ext;
    flip_d = 1'b0;
    if (d_ext > QUARTER_TURN) begin
      d_red  = d_ext - HALF_TURN;
      flip_d = 1'b1;
    end else if (d_ext < -QUARTER_TURN) begin
      d_red  = d_ext + HALF_TURN;
      flip_d = 1'b1;
    end
    mag_d = d_red[17] ? 15'(-d_red) : 15'(d_red);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag_q   <= mag_d;
      neg_q0  <= d_red[17];
      flip_q0 <= flip_d;
    end
  end

  // Stage 1: integer and fractional parts of the radian scale.
  logic [31:0] hi_q1, hi_q2;
  logic [18:0] m_q1;
  logic [28:0] num;
  logic        neg_q1, flip_q1, neg_q2, flip_q2;

  assign num = 29'(mag_q) * 29'(RAD_FRAC) + 29'(RAD_HALF);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      hi_q1   <= 32'(mag_q) * 32'(RAD_INT);
      m_q1    <= num[28:10];
      neg_q1  <= neg_q0;
      flip_q1 <= flip_q0;
    end
  end

  // Stage 2: divide by 45 through the reciprocal.
  logic [38:0] prod_q2;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      prod_q2 <= 39'(m_q1) * 39'(RECIP_45);
      hi_q2   <= hi_q1;
      neg_q2  <= neg_q1;
      flip_q2 <= flip_q1;
    end
  end

  // Stage 3: radian angle in Q30 with its sign restored.
  logic [31:0]            zmag;
  logic signed [CW-1:0]   x_q [NSTEP+1];
  logic signed [CW-1:0]   y_q [NSTEP+1];
  logic signed [CW-1:0]   z_q [NSTEP+1];
  logic                   f_q [NSTEP+1];

  assign zmag = hi_q2 + 32'(prod_q2[38:25]);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      z_q[0] <= neg_q2 ? -CW'(zmag) : CW'(zmag);
      x_q[0] <= CORDIC_GAIN;
      y_q[0] <= '0;
      f_q[0] <= flip_q2;
    end
  end

  // CORDIC rotation steps, one per stage.
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic signed [CW-1:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = CW'(ATAN_Q30[i]);
    always_ff @(posedge clk_i) begin
      if (en_i[4+i]) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        f_q[i+1] <= f_q[i];
      end
    end
  end

  // Final stage: undo the half-turn fold.
  always_ff @(posedge clk_i) begin
    if (en_i[NSTEP+4]) begin
      cos_o <= f_q[NSTEP] ? SC_W'(-x_q[NSTEP]) : SC_W'(x_q[NSTEP]);
      sin_o <= f_q[NSTEP] ? SC_W'(-y_q[NSTEP]) : SC_W'(y_q[NSTEP]);
    end
  end

endmodule

>>> sv/e2q_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_merge: quaternion components from the three lanes
// Pair products, rounding, triple products, sums, final round and clamp.
// ----------------------------------------------------------------------------
module e2q_merge
  import e2q_pkg::*;
(
  input  logic                       clk_i,
  input  logic [MERGE_STAGES-1:0]    en_i,
  input  logic signed [SC_W-1:0]     sa_i,
  input  logic signed [SC_W-1:0]     ca_i,
  input  logic signed [SC_W-1:0]     sb_i,
  input  logic signed [SC_W-1:0]     cb_i,
  input  logic signed [SC_W-1:0]     sc_i,
  input  logic signed [SC_W-1:0]     cc_i,
  output logic signed [QUAT_W-1:0]   quat_w_o,
  output logic signed [QUAT_W-1:0]   quat_x_o,
  output logic signed [QUAT_W-1:0]   quat_y_o,
  output logic signed [QUAT_W-1:0]   quat_z_o
);

  localparam logic signed [63:0] HALF30  = 64'sd1 <<< 29;
  localparam logic signed [63:0] HALFRES = 64'sd1 <<< (RES_SHIFT - 1);
  localparam logic signed [63:0] OUT_MAX = 64'sd32767;
  localparam logic signed [63:0] OUT_MIN = -64'sd32768;

  // Pairs: 0 = cb*cc, 1 = sb*sc, 2 = sb*cc, 3 = cb*sc.
  logic signed [63:0]   pp_q [4];
  logic signed [RW-1:0] r_q  [4];
  logic signed [SC_W-1:0] sa_q0, ca_q0, sa_q1, ca_q1;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_q[0] <= cb_i * cc_i;
      pp_q[1] <= sb_i * sc_i;
      pp_q[2] <= sb_i * cc_i;
      pp_q[3] <= cb_i * sc_i;
      sa_q0   <= sa_i;
      ca_q0   <= ca_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < 4; k++) begin
        r_q[k] <= RW'((pp_q[k] + HALF30) >>> 30);
      end
      sa_q1 <= sa_q0;
      ca_q1 <= ca_q0;
    end
  end

  logic signed [63:0] t_q [8];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      t_q[0] <= 64'(r_q[0]) * 64'(ca_q1);
      t_q[1] <= 64'(r_q[1]) * 64'(sa_q1);
      t_q[2] <= 64'(r_q[1]) * 64'(ca_q1);
      t_q[3] <= 64'(r_q[0]) * 64'(sa_q1);
      t_q[4] <= 64'(r_q[2]) * 64'(ca_q1);
      t_q[5] <= 64'(r_q[3]) * 64'(sa_q1);
      t_q[6] <= 64'(r_q[3]) * 64'(ca_q1);
      t_q[7] <= 64'(r_q[2]) * 64'(sa_q1);
    end
  end

  logic signed [63:0] s_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s_q[0] <= t_q[0] - t_q[1];
      s_q[1] <= t_q[2] + t_q[3];
      s_q[2] <= t_q[4] + t_q[5];
      s_q[3] <= t_q[6] - t_q[7];
    end
  end

  logic signed [QUAT_W-1:0] res [4];

  for (genvar k = 0; k < 4; k++) begin : g_fin
    logic signed [63:0] v;
    assign v = (s_q[k] + HALFRES) >>> RES_SHIFT;
    always_comb begin
      if (v > OUT_MAX) begin
        res[k] = QUAT_W'(OUT_MAX);
      end else if (v < OUT_MIN) begin
        res[k] = QUAT_W'(OUT_MIN);
      end else begin
        res[k] = QUAT_W'(v);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      quat_w_o <= res[0];
      quat_x_o <= res[1];
      quat_y_o <= res[2];
      quat_z_o <= res[3];
    end
  end

endmodule

>>> sv/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion: three Euler angles to a unit quaternion
// Three parallel sine/cosine lanes feed a pipelined merge of triple products.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake          | Payload
//   angles  | in        | valid_i / stall_o  | angle_a_i, angle_b_i, angle_c_i
//   quat    | out       | valid_o / stall_i  | quat_w_o, quat_x_o, quat_y_o, quat_z_o
//
// One transaction is accepted per cycle while stall_o is low; its result
// shows on valid_o once it has passed through every pipeline stage. The
// depth is set by the CORDIC chain of one stage per step plus the
// conversion and product stages.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall holds only the stages that are full behind it, so empty stages keep
// filling; input is taken while a result waits at the output if any stage is empty.
// ----------------------------------------------------------------------------
module euler_to_quaternion
  import e2q_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [ANGLE_W-1:0] angle_a_i,
  input  logic signed [ANGLE_W-1:0] angle_b_i,
  input  logic signed [ANGLE_W-1:0] angle_c_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic signed [QUAT_W-1:0]  quat_w_o,
  output logic signed [QUAT_W-1:0]  quat_x_o,
  output logic signed [QUAT_W-1:0]  quat_y_o,
  output logic signed [QUAT_W-1:0]  quat_z_o
);

  // Per-stage occupancy and load enables. A stage may load when it is
  // empty or when its own content moves on in the same cycle.
  logic [PIPE_STAGES-1:0] vld_q, vld_d;
  logic [PIPE_STAGES:0]   rdy;
  logic [PIPE_STAGES-1:0] src;

  always_comb begin
    rdy[PIPE_STAGES] = !stall_i;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign src = {vld_q[PIPE_STAGES-2:0], valid_i};

  always_comb begin
    for (int k = 0; k < PIPE_STAGES; k++) begin
      vld_d[k] = rdy[k] ? src[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = vld_q[PIPE_STAGES-1];

  logic [LANE_STAGES-1:0]  lane_en;
  logic [MERGE_STAGES-1:0] merge_en;

  assign lane_en  = rdy[LANE_STAGES-1:0];
  assign merge_en = rdy[PIPE_STAGES-1:LANE_STAGES];

  logic signed [SC_W-1:0] sa, ca, sb, cb, sc, cc;

  e2q_lane u_lane_a (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .angle_i (angle_a_i),
    .sin_o   (sa),
    .cos_o   (ca)
  );

  e2q_lane u_lane_b (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .angle_i (angle_b_i),
    .sin_o   (sb),
    .cos_o   (cb)
  );

  e2q_lane u_lane_c (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .angle_i (angle_c_i),
    .sin_o   (sc),
    .cos_o   (cc)
  );

  e2q_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (merge_en),
    .sa_i     (sa),
    .ca_i     (ca),
    .sb_i     (sb),
    .cb_i     (cb),
    .sc_i     (sc),
    .cc_i     (cc),
    .quat_w_o (quat_w_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o)
  );

endmodule
